[rtl/temp_reading_to_digits_and_fan_speed_core_assert.svh]
// assertion helpers for the temperature core
// both sample on i_clk and are off while i_rst_n is low
`ifndef TEMP_READING_TO_DIGITS_AND_FAN_SPEED_CORE_ASSERT_SVH
`define TEMP_READING_TO_DIGITS_AND_FAN_SPEED_CORE_ASSERT_SVH

// same-cycle implication
`define TRDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/trdf_pkg.sv]
package trdf_pkg;

    localparam int unsigned RAW_W   = 16;
    localparam int unsigned THR_W   = 7;
    localparam int unsigned SPD_W   = 14;
    localparam int unsigned T16_W   = THR_W + 4;          // thresholds in sixteenths
    localparam int unsigned PROD_W  = SPD_W + T16_W;      // full_speed * ramp offset
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned NSTAGE  = 2 + SPD_W;          // decode, multiply, one per quotient bit

    localparam logic [THR_W-1:0] LOW_RST  = THR_W'(60);
    localparam logic [THR_W-1:0] HIGH_RST = THR_W'(80);
    localparam logic [SPD_W-1:0] FULL_RST = SPD_W'(3000);

    localparam logic [CIDX_W-1:0] CFG_LOW  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_HIGH = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_FULL = 2'd2;

    typedef struct packed {
        logic              neg;
        logic [7:0]        whole;
        logic [3:0]        nib;
        logic              hund;
        logic [3:0]        tens;
        logic [3:0]        ones;
        logic [15:0]       frac;    // four bcd digits, tenths on top
        logic              on;
        logic              sat;
        logic [SPD_W-1:0]  fs;
        logic [T16_W-1:0]  num;
        logic [T16_W-1:0]  den;
        logic [PROD_W-1:0] rem;
        logic [SPD_W-1:0]  quo;
    } t_item;

    // nibble * 625 as four bcd digits
    function automatic logic [15:0] frac_bcd(input logic [3:0] nib);
        logic [15:0] d;
        unique case (nib)
            4'd0:    d = 16'h0000;
            4'd1:    d = 16'h0625;
            4'd2:    d = 16'h1250;
            4'd3:    d = 16'h1875;
            4'd4:    d = 16'h2500;
            4'd5:    d = 16'h3125;
            4'd6:    d = 16'h3750;
            4'd7:    d = 16'h4375;
            4'd8:    d = 16'h5000;
            4'd9:    d = 16'h5625;
            4'd10:   d = 16'h6250;
            4'd11:   d = 16'h6875;
            4'd12:   d = 16'h7500;
            4'd13:   d = 16'h8125;
            4'd14:   d = 16'h8750;
            default: d = 16'h9375;
        endcase
        return d;
    endfunction

endpackage

[rtl/trdf_if.sv]
interface trdf_in_if import trdf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_reading;

    modport source (output valid, output raw_reading, input ready);
    modport sink   (input valid, input raw_reading, output ready);
endinterface

interface trdf_out_if import trdf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             is_negative;
    logic             digit_hundreds;
    logic [3:0]       digit_tens;
    logic [3:0]       digit_ones;
    logic [3:0]       frac_tenths;
    logic [3:0]       frac_hundredths;
    logic [3:0]       frac_thousandths;
    logic [3:0]       frac_ten_thousandths;
    logic             fan_on;
    logic [SPD_W-1:0] fan_speed;

    modport source (output valid, output is_negative, output digit_hundreds,
                    output digit_tens, output digit_ones, output frac_tenths,
                    output frac_hundredths, output frac_thousandths,
                    output frac_ten_thousandths, output fan_on, output fan_speed,
                    input ready);
    modport sink   (input valid, input is_negative, input digit_hundreds,
                    input digit_tens, input digit_ones, input frac_tenths,
                    input frac_hundredths, input frac_thousandths,
                    input frac_ten_thousandths, input fan_on, input fan_speed,
                    output ready);
endinterface

interface trdf_cfg_if import trdf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [SPD_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/trdf_div_step.sv]
module trdf_div_step import trdf_pkg::*; #(
    parameter int unsigned BIT = 0
) (
    input  t_item i_item,
    output t_item o_item
);

    logic [PROD_W-1:0] w_dsh;
    logic              w_ge;

    // restoring step: try den shifted to this quotient bit
    assign w_dsh = PROD_W'(i_item.den) << BIT;
    assign w_ge  = i_item.rem >= w_dsh;

    always_comb begin
        o_item          = i_item;
        o_item.rem      = w_ge ? (i_item.rem - w_dsh) : i_item.rem;
        o_item.quo[BIT] = w_ge;
    end

endmodule

[rtl/temp_reading_to_digits_and_fan_speed_core.sv]
// channel  dir  signals                                   accepted when
// i_in     in   valid ready raw_reading                   valid && ready
// o_out    out  valid ready is_negative .. fan_speed      valid && ready
// i_cfg    in   valid ready index data                    valid && ready (ready tied high)
//
// one item per cycle sustained while o_out is ready; the pipe is a decode stage, a multiply
//   stage and fourteen restoring divider stages, one quotient bit each
// each stage has its own valid bit and loads when empty or when the stage after it moves
// a stall at o_out backs up stage by stage; bubbles are squeezed out before i_in stalls
// reset clears the valid bits and loads the threshold and speed registers
`include "temp_reading_to_digits_and_fan_speed_core_assert.svh"

module temp_reading_to_digits_and_fan_speed_core import trdf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    trdf_in_if.sink     i_in,
    trdf_out_if.source  o_out,
    trdf_cfg_if.sink    i_cfg
);

    // configuration registers
    logic [THR_W-1:0] r_low;
    logic [THR_W-1:0] r_high;
    logic [SPD_W-1:0] r_full;

    // pipeline
    logic [NSTAGE-1:0] r_v;
    t_item             r_s   [NSTAGE];
    t_item             n_s   [NSTAGE];
    logic [NSTAGE:0]   w_rdy;
    logic [NSTAGE-1:0] w_vin;

    // decode stage signals
    logic              w_neg;
    logic [RAW_W-1:0]  w_negv;
    logic [11:0]       w_mag;
    logic signed [12:0] w_tsig;
    logic [T16_W-1:0]  w_lo16;
    logic [T16_W-1:0]  w_hi16;
    t_item             w_s0;

    // multiply stage signals
    logic [6:0]        w_rest;
    logic [14:0]       w_tmul;
    logic [3:0]        w_tens;
    t_item             w_s1;

    t_item             w_last;

    // ---------------------------------------------------------------
    // config writes, always taken; index 3 is dropped
    // ---------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= LOW_RST;
            r_high <= HIGH_RST;
            r_full <= FULL_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_LOW:  r_low  <= i_cfg.data[THR_W-1:0];
                CFG_HIGH: r_high <= i_cfg.data[THR_W-1:0];
                CFG_FULL: r_full <= i_cfg.data;
                default:  ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // decode: sign, magnitude, threshold compares, ramp operands
    // ---------------------------------------------------------------
    assign w_neg  = &i_in.raw_reading[15:11];
    assign w_negv = (~i_in.raw_reading) + RAW_W'(1);
    // most negative word keeps bit 11, reads as 128.0
    assign w_mag  = w_neg ? w_negv[11:0] : {1'b0, i_in.raw_reading[10:0]};
    assign w_tsig = w_neg ? (13'sd0 - $signed({1'b0, w_mag})) : $signed({1'b0, w_mag});
    assign w_lo16 = {r_low, 4'b0000};
    assign w_hi16 = {r_high, 4'b0000};

    always_comb begin
        w_s0       = '0;
        w_s0.neg   = w_neg;
        w_s0.whole = w_mag[11:4];
        w_s0.nib   = w_mag[3:0];
        w_s0.on    = w_tsig >= $signed({2'b00, w_lo16});
        w_s0.sat   = w_tsig >= $signed({2'b00, w_hi16});
        w_s0.fs    = r_full;
        // only meaningful inside the ramp, where low <= t < high
        w_s0.num   = w_tsig[T16_W-1:0] - w_lo16;
        w_s0.den   = w_hi16 - w_lo16;
    end

    // ---------------------------------------------------------------
    // integer and fraction digits, ramp product
    // ---------------------------------------------------------------
    always_comb begin
        w_s1      = r_s[0];
        w_s1.hund = r_s[0].whole >= 8'd100;
        w_s1.frac = frac_bcd(r_s[0].nib);
        w_s1.rem  = PROD_W'(r_s[0].fs) * PROD_W'(r_s[0].num);
        w_s1.quo  = '0;
        w_s1.tens = w_tens;
        w_s1.ones = 4'(w_rest - 7'({w_tens, 3'b000}) - 7'({w_tens, 1'b0}));
    end

    assign w_rest = (r_s[0].whole >= 8'd100) ? 7'(r_s[0].whole - 8'd100) :
                                               r_s[0].whole[6:0];
    // x*205 >> 11 is x/10 for x below 100
    assign w_tmul = 15'(w_rest) * 15'd205;
    assign w_tens = w_tmul[14:11];

    assign n_s[0] = w_s0;
    assign n_s[1] = w_s1;

    // ---------------------------------------------------------------
    // divider: quotient is below full_speed, so 14 bits, msb first
    // ---------------------------------------------------------------
    for (genvar g = 0; g < SPD_W; g++) begin : g_div
        trdf_div_step #(
            .BIT (SPD_W - 1 - g)
        ) u_step (
            .i_item (r_s[1+g]),
            .o_item (n_s[2+g])
        );
    end

    // ---------------------------------------------------------------
    // per-stage handshake
    // ---------------------------------------------------------------
    assign w_vin = {r_v[NSTAGE-2:0], i_in.valid};

    always_comb begin
        w_rdy[NSTAGE] = o_out.ready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign i_in.ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTAGE; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= w_vin[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTAGE; k++) begin
            if (w_rdy[k]) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // result
    // ---------------------------------------------------------------
    assign w_last = r_s[NSTAGE-1];

    assign o_out.valid                = r_v[NSTAGE-1];
    assign o_out.is_negative          = w_last.neg;
    assign o_out.digit_hundreds       = w_last.hund;
    assign o_out.digit_tens           = w_last.tens;
    assign o_out.digit_ones           = w_last.ones;
    assign o_out.frac_tenths          = w_last.frac[15:12];
    assign o_out.frac_hundredths      = w_last.frac[11:8];
    assign o_out.frac_thousandths     = w_last.frac[7:4];
    assign o_out.frac_ten_thousandths = w_last.frac[3:0];
    assign o_out.fan_on               = w_last.on;
    // fan off gives zero, at or above high gives full speed, else the ramp
    assign o_out.fan_speed            = !w_last.on ? '0 :
                                        (w_last.sat ? w_last.fs : w_last.quo);

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `TRDF_ASSERT_NEXT(a_in_lands, i_in.valid && i_in.ready, r_v[0], "accepted item not in stage 0")
    `TRDF_ASSERT_NEXT(a_stall_holds, r_v[NSTAGE-1] && !o_out.ready, r_v[NSTAGE-1] && $stable(w_last), "stalled result changed")
    `TRDF_ASSERT_NOW(a_speed_bound, o_out.valid, o_out.fan_speed <= w_last.fs, "fan speed above full speed")
    `TRDF_ASSERT_NOW(a_off_zero, o_out.valid && !o_out.fan_on, o_out.fan_speed == '0, "fan off with nonzero speed")
    `TRDF_ASSERT_NOW(a_bcd_digits, o_out.valid, o_out.digit_tens <= 4'd9 && o_out.digit_ones <= 4'd9, "integer digit out of range")

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench import trdf_pkg::*;;

    // index past the last register, writes to it must be dropped
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = NSTAGE + 4;

    // one expected readout, fields at the widths of the output channel
    typedef struct packed {
        logic             neg;
        logic             hund;
        logic [3:0]       tens;
        logic [3:0]       ones;
        logic [3:0]       tenths;
        logic [3:0]       hundredths;
        logic [3:0]       thousandths;
        logic [3:0]       ten_thousandths;
        logic             on;
        logic [SPD_W-1:0] speed;
    } t_readout;

    logic i_clk;
    logic i_rst_n;

    trdf_in_if  in_ch ();
    trdf_out_if out_ch ();
    trdf_cfg_if cfg_ch ();

    temp_reading_to_digits_and_fan_speed_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // shadow copy of the fan curve registers
    logic [THR_W-1:0] low_thr;
    logic [THR_W-1:0] high_thr;
    logic [SPD_W-1:0] full_spd;

    t_readout pending_readouts[$];
    int       error_count = 0;
    int       stall_left;
    bit       idle_en;

    // clock, 8 ns period
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // hard limit on run time
    initial begin
        #2_000_000;
        $display("** temp_reading_to_digits_and_fan_speed_core: FAILED **");
        $finish;
    end

    // sensor word to display digits and fan command
    function automatic t_readout convert_reading(input logic [RAW_W-1:0] raw);
        t_readout   r;
        logic [11:0] mag;
        int         whole;
        int         frac;
        int         tsig;
        int         lo16;
        int         hi16;
        r = '0;
        // negative only when the whole sign extension is set
        r.neg = &raw[15:11];
        // the most negative word keeps its twelfth bit and reads 128.0000
        mag   = r.neg ? (~raw[11:0] + 12'd1) : {1'b0, raw[10:0]};
        whole = int'(mag >> 4);
        frac  = int'(mag[3:0]) * 625;
        r.hund            = 1'((whole / 100) & 1);
        r.tens            = 4'((whole / 10) % 10);
        r.ones            = 4'(whole % 10);
        r.tenths          = 4'(frac / 1000);
        r.hundredths      = 4'((frac / 100) % 10);
        r.thousandths     = 4'((frac / 10) % 10);
        r.ten_thousandths = 4'(frac % 10);
        tsig = r.neg ? -int'(mag) : int'(mag);
        lo16 = int'(low_thr) * 16;
        hi16 = int'(high_thr) * 16;
        if (tsig >= lo16) begin
            r.on = 1'b1;
            // a high threshold at or below low never reaches the ramp
            if (tsig >= hi16)
                r.speed = full_spd;
            else
                r.speed = SPD_W'((int'(full_spd) * (tsig - lo16)) / (hi16 - lo16));
        end
        return r;
    endfunction

    // random sensor word, weighted toward the fan band and negative words
    function automatic logic [RAW_W-1:0] draw_reading();
        logic [RAW_W-1:0] raw;
        int lo_b;
        int hi_b;
        lo_b = (low_thr < high_thr ? int'(low_thr) : int'(high_thr)) * 16 - 40;
        hi_b = (low_thr < high_thr ? int'(high_thr) : int'(low_thr)) * 16 + 40;
        if (lo_b < 0) lo_b = 0;
        if (hi_b > 2047) hi_b = 2047;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: raw = RAW_W'($urandom);
            4, 5, 6:    raw = {5'b00000, 11'($urandom_range(lo_b, hi_b))};
            7, 8:       raw = {5'b11111, 11'($urandom)};
            default:    raw = {5'($urandom_range(0, 30)), 11'($urandom)};
        endcase
        return raw;
    endfunction

    task automatic compare_field(input string field_name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field_name, want, got);
            error_count++;
        end
    endtask

    task automatic check_readout();
        t_readout want;
        if (pending_readouts.size() == 0) begin
            $error("readout with no reading pending");
            error_count++;
        end else begin
            want = pending_readouts.pop_front();
            compare_field("is_negative", 16'(want.neg), 16'(out_ch.is_negative));
            compare_field("digit_hundreds", 16'(want.hund), 16'(out_ch.digit_hundreds));
            compare_field("digit_tens", 16'(want.tens), 16'(out_ch.digit_tens));
            compare_field("digit_ones", 16'(want.ones), 16'(out_ch.digit_ones));
            compare_field("frac_tenths", 16'(want.tenths), 16'(out_ch.frac_tenths));
            compare_field("frac_hundredths", 16'(want.hundredths),
                          16'(out_ch.frac_hundredths));
            compare_field("frac_thousandths", 16'(want.thousandths),
                          16'(out_ch.frac_thousandths));
            compare_field("frac_ten_thousandths", 16'(want.ten_thousandths),
                          16'(out_ch.frac_ten_thousandths));
            compare_field("fan_on", 16'(want.on), 16'(out_ch.fan_on));
            compare_field("fan_speed", 16'(want.speed), 16'(out_ch.fan_speed));
        end
    endtask

    // readout side: check every accepted item, then maybe stall when idling is enabled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                check_readout();
                stall_left = idle_en ? $urandom_range(0, 3) : 0;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // one sensor word; valid stays up when the next item follows at once
    task automatic send_reading(input logic [RAW_W-1:0] raw);
        int gap;
        gap = idle_en ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.raw_reading <= raw;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_readouts.push_back(convert_reading(raw));
    endtask

    // stop sending and let every readout come back
    task automatic drain_readouts();
        in_ch.valid <= 1'b0;
        while (pending_readouts.size() != 0) @(posedge i_clk);
    endtask

    // leaves valid high so back to back writes need one assignment per step
    task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [SPD_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_LOW:  low_thr  = data[THR_W-1:0];
            CFG_HIGH: high_thr = data[THR_W-1:0];
            CFG_FULL: full_spd = data;
            default:  ;
        endcase
    endtask

    // only called with the pipe empty; the unused index is hit every time
    task automatic set_fan_curve(input int lo, input int hi, input int fs);
        write_register(CFG_FULL, SPD_W'(fs));
        write_register(CFG_UNUSED, SPD_W'($urandom));
        write_register(CFG_LOW, SPD_W'(lo));
        write_register(CFG_HIGH, SPD_W'(hi));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_random_readings(input int count);
        repeat (count) send_reading(draw_reading());
        drain_readouts();
    endtask

    // reset curve, digit extremes and the sign corner cases
    task automatic test_reset_curve();
        logic [RAW_W-1:0] words[$];
        words = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07FF, 16'h0800, 16'h7FFF,
                  16'h8000, 16'hF000, 16'hFC90, 16'h03BF, 16'h03C0, 16'h0460,
                  16'h04FF, 16'h0500, 16'h0199, 16'hAAAA};
        idle_en = 1'b1;
        foreach (words[i]) send_reading(words[i]);
        drain_readouts();
    endtask

    // a write past the last register must leave the curve alone
    task automatic test_unused_index();
        write_register(CFG_UNUSED, SPD_W'(16383));
        cfg_ch.valid <= 1'b0;
        send_reading(16'h0460);
        send_reading(16'h0500);
        send_reading(16'h5555);
        drain_readouts();
    endtask

    // widest ramp, inverted and equal thresholds, zero and maximum speed
    task automatic test_curve_extremes();
        set_fan_curve(0, 127, 16383);
        idle_en = 1'b0;
        run_random_readings(150);
        set_fan_curve(127, 0, 16383);
        idle_en = 1'b1;
        run_random_readings(150);
        set_fan_curve(50, 50, 1);
        run_random_readings(120);
        set_fan_curve(0, 0, 0);
        idle_en = 1'b0;
        run_random_readings(120);
        set_fan_curve(127, 127, 16383);
        idle_en = 1'b1;
        run_random_readings(120);
        set_fan_curve(0, 1, 16383);
        run_random_readings(120);
    endtask

    // random curves, idling on and off by phase
    task automatic test_random_curves();
        for (int phase = 0; phase < 8; phase++) begin
            set_fan_curve($urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 16383));
            idle_en = phase[0];
            run_random_readings(130);
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.raw_reading  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_LOW;
        cfg_ch.data        = '0;
        low_thr            = LOW_RST;
        high_thr           = HIGH_RST;
        full_spd           = FULL_RST;
        idle_en            = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_curve();
        test_unused_index();
        test_curve_extremes();
        test_random_curves();

        // nothing is pending; give the pipe its depth to show a stray item
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_readouts.size() != 0)
            $error("%0d readouts never arrived", pending_readouts.size());
        if (error_count == 0 && pending_readouts.size() == 0)
            $display("** temp_reading_to_digits_and_fan_speed_core: PASSED **");
        else
            $display("** temp_reading_to_digits_and_fan_speed_core: FAILED **");
        $finish;
    end

endmodule

[temp_reading_to_digits_and_fan_speed_core.f]
+incdir+rtl
rtl/trdf_pkg.sv
rtl/trdf_if.sv
rtl/trdf_div_step.sv
rtl/temp_reading_to_digits_and_fan_speed_core.sv
bench/testbench.sv
